[hdl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, types and round functions for the SHA-256 message hash.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 3;
    localparam int FILL_W  = 6;
    localparam int ROUND_W = 6;
    localparam int LEN_W   = 64;
    localparam int NUM_H   = 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LAST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Byte source for the block shift line
    localparam logic [1:0] BSRC_DATA = 2'd0;
    localparam logic [1:0] BSRC_MARK = 2'd1;
    localparam logic [1:0] BSRC_ZERO = 2'd2;
    localparam logic [1:0] BSRC_LEN  = 2'd3;

    localparam logic [BYTE_W-1:0]  PAD_MARK  = 8'h80;
    localparam logic [FILL_W-1:0]  FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0]  LEN_POS   = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [IDX_W-1:0]   IDX_LAST  = 3'd7;
    localparam logic [LEN_W-1:0]   BYTE_BITS = 64'd8;

    typedef struct packed {
        logic               shift_en;
        logic [1:0]         byte_src;
        logic               count_en;
        logic               load_work;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               update_en;
        logic               final_en;
    } sha_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              out_busy;
    } sha_sts_t;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] init_h(input logic [IDX_W-1:0] i);
        logic [WORD_W-1:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] i);
        logic [WORD_W-1:0] r;
        case (i)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

[hdl/sha_in_if.sv]
// ----------------------------------------------------------------------------
// sha_in_if
// Message byte channel: valid/ready with kind and data byte.
// ----------------------------------------------------------------------------
interface sha_in_if;
    import sha_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

[hdl/sha_out_if.sv]
// ----------------------------------------------------------------------------
// sha_out_if
// Digest word channel: valid/ready with word, index and last flag.
// ----------------------------------------------------------------------------
interface sha_out_if;
    import sha_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

[hdl/sha_datapath.sv]
// ----------------------------------------------------------------------------
// sha_datapath
// Block shift line doubling as the message schedule window, round unit,
// chaining words, bit counter and the digest bank that drains to the output.
// ----------------------------------------------------------------------------
module sha_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha_pkg::sha_cmd_t         cmd,
    input  logic [sha_pkg::BYTE_W-1:0] data_byte,
    output sha_pkg::sha_sts_t         sts,
    sha_out_if.source                 digest
);
    import sha_pkg::*;

    localparam int BLK_W = 16 * WORD_W;

    logic [BLK_W-1:0]  win_reg;
    logic [WORD_W-1:0] hash_reg [NUM_H];
    logic [WORD_W-1:0] work_reg [NUM_H];
    logic [WORD_W-1:0] dig_reg  [NUM_H];
    logic [FILL_W-1:0] fill_reg;
    logic [LEN_W-1:0]  bitcnt_reg;
    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [BYTE_W-1:0] byte_in;
    logic [LEN_W-1:0]  len_sh;
    logic [WORD_W-1:0] w0, w1, w9, w14, w_new;
    logic [WORD_W-1:0] t1, t2, ch, maj;

    // Length bytes go out most significant first at positions 56..63
    assign len_sh = bitcnt_reg >> {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_src)
            BSRC_DATA: byte_in = data_byte;
            BSRC_MARK: byte_in = PAD_MARK;
            BSRC_LEN:  byte_in = len_sh[BYTE_W-1:0];
            default:   byte_in = '0;
        endcase
    end

    assign w0  = win_reg[BLK_W-1 -: WORD_W];
    assign w1  = win_reg[BLK_W-1-WORD_W -: WORD_W];
    assign w9  = win_reg[BLK_W-1-9*WORD_W -: WORD_W];
    assign w14 = win_reg[BLK_W-1-14*WORD_W -: WORD_W];
    assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

    always_comb
    begin
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1  = work_reg[7] + bsig1(work_reg[4]) + ch + round_k(cmd.round_idx) + w0;
        t2  = bsig0(work_reg[0]) + maj;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            win_reg <= {win_reg[BLK_W-BYTE_W-1:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            win_reg <= {win_reg[BLK_W-WORD_W-1:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int k = 0; k < NUM_H; k++)
            begin
                work_reg[k] <= hash_reg[k];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.final_en)
        begin
            for (int k = 0; k < NUM_H; k++)
            begin
                dig_reg[k] <= hash_reg[k] + work_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_H; k++)
            begin
                hash_reg[k] <= init_h(IDX_W'(k));
            end
            fill_reg   <= '0;
            bitcnt_reg <= '0;
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            if (cmd.shift_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.count_en)
            begin
                bitcnt_reg <= bitcnt_reg + BYTE_BITS;
            end
            if (cmd.update_en)
            begin
                for (int k = 0; k < NUM_H; k++)
                begin
                    hash_reg[k] <= hash_reg[k] + work_reg[k];
                end
            end
            if (cmd.final_en)
            begin
                // restart the chain for the next message
                for (int k = 0; k < NUM_H; k++)
                begin
                    hash_reg[k] <= init_h(IDX_W'(k));
                end
                bitcnt_reg <= '0;
                busy_reg   <= 1'b1;
                idx_reg    <= '0;
            end
            else if (digest.valid && digest.ready)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign digest.valid       = busy_reg;
    assign digest.digest_word = dig_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == IDX_LAST);

    assign sts.fill     = fill_reg;
    assign sts.out_busy = busy_reg;

endmodule

[hdl/sha_ctrl.sv]
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, 64 compression rounds, chaining update
// and hand-off of the digest to the output bank.
// ----------------------------------------------------------------------------
module sha_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [sha_pkg::KIND_W-1:0] in_kind,
    output logic                      in_ready,
    input  sha_pkg::sha_sts_t         sts,
    output sha_pkg::sha_cmd_t         cmd
);
    import sha_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PAD    = 2'd1;
    localparam logic [1:0] ST_ROUND  = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [ROUND_W-1:0] round_reg,  round_next;
    logic               pad_reg,    pad_next;
    logic               mark_reg,   mark_next;
    logic               lenok_reg,  lenok_next;
    logic               block_full;

    assign block_full = (sts.fill == FILL_LAST);
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        lenok_next = lenok_reg;
        cmd        = '0;
        cmd.round_idx = round_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_DATA, KIND_LAST:
                        begin
                            cmd.shift_en = 1'b1;
                            cmd.byte_src = BSRC_DATA;
                            cmd.count_en = 1'b1;
                            if (in_kind == KIND_LAST)
                            begin
                                pad_next   = 1'b1;
                                state_next = ST_PAD;
                            end
                            if (block_full)
                            begin
                                cmd.load_work = 1'b1;
                                round_next    = '0;
                                state_next    = ST_ROUND;
                            end
                        end
                        KIND_END:
                        begin
                            pad_next   = 1'b1;
                            state_next = ST_PAD;
                        end
                        default:
                        begin
                            // drop unused kind
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                if (!mark_reg)
                begin
                    cmd.byte_src = BSRC_MARK;
                    mark_next    = 1'b1;
                    // length fits in this block only if the mark lands before it
                    if (sts.fill < LEN_POS)
                    begin
                        lenok_next = 1'b1;
                    end
                end
                else if (lenok_reg && sts.fill >= LEN_POS)
                begin
                    cmd.byte_src = BSRC_LEN;
                end
                else
                begin
                    cmd.byte_src = BSRC_ZERO;
                end
                if (block_full)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (pad_reg && lenok_reg)
                begin
                    // hold until the previous digest has drained
                    if (!sts.out_busy)
                    begin
                        cmd.final_en = 1'b1;
                        pad_next     = 1'b0;
                        mark_next    = 1'b0;
                        lenok_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.update_en = 1'b1;
                    if (pad_reg)
                    begin
                        if (mark_reg)
                        begin
                            lenok_next = 1'b1;
                        end
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            lenok_reg <= lenok_next;
        end
    end

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == ROUND_LAST) |=> state_reg == ST_UPDATE)
        else $error("round sequence did not end in update");

    a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_en |-> !sts.out_busy)
        else $error("digest bank overwritten while draining");

    a_lenok_mark: assert property (@(posedge clk) disable iff (!rst_n)
        lenok_reg |-> (mark_reg && pad_reg))
        else $error("length enabled before padding mark");

    a_pad_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (cmd.byte_src != BSRC_DATA))
        else $error("message byte shifted during padding");

    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_work |=> (state_reg == ST_ROUND && round_reg == '0
                           && $past(sts.fill) == FILL_LAST))
        else $error("compression started on a partial block");

endmodule

[hdl/sha256_message_hash.sv]
// ----------------------------------------------------------------------------
// sha256_message_hash
// SHA-256 over a byte stream; emits the eight digest words per message.
//
//   channel | dir | payload                                | role
//   msg     | in  | kind[1:0], data_byte[7:0]              | message bytes / finish
//   digest  | out | digest_word[31:0], word_index[2:0], last_word | hash words
//
// Data bytes are taken while the sequencer is idle; the 64th byte of a block
// starts the rounds and the chaining update on the single shared round unit.
// Finish shifts padding one byte a cycle, pausing while a block compresses,
// and runs one or two compressions.
// Reset loads the initial hash words and clears the byte and bit counts.
// The digest drains from its own bank; the next message loads meanwhile, and
// only its final digest hand-off waits for the previous digest to drain.
// ----------------------------------------------------------------------------
module sha256_message_hash
(
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    msg,
    sha_out_if.source digest
);
    import sha_pkg::*;

    sha_cmd_t cmd;
    sha_sts_t sts;

    sha_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_kind  (msg.kind),
        .in_ready (msg.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sha_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (msg.data_byte),
        .sts       (sts),
        .digest    (digest)
    );

endmodule

[tb/tb_sha256_message_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_message_hash
// Streams byte messages into the hasher and checks every digest word.
//
// A short table covers the empty message, the "abc" vector, the item kinds
// and the byte extremes. Random messages follow, mostly short, some at the
// block and padding edges. An in-bench SHA-256 model predicts the words
// except for rows with a known digest. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sha256_message_hash;
    import sha_pkg::*;

    localparam int CLK_HALF     = 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 445;
    localparam int DRAIN_CYCLES = 400;
    localparam int REPORT_MAX   = 10;

    // kind value the block must drop
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } digest_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic              gold_valid;
        logic [255:0]      gold;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sha_in_if  msg_ch ();
    sha_out_if dig_ch ();

    sha256_message_hash dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    logic [31:0] round_const [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] start_chain [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // model state
    logic [31:0]       chain [8];
    logic [BYTE_W-1:0] block_bytes [64];
    int unsigned       fill;
    logic [63:0]       bit_len;

    digest_entry_t pending_words [$];
    stim_row_t     stim_table [$];

    int unsigned cycles;
    int unsigned mismatch_count;
    int unsigned words_checked;
    int unsigned messages_sent;
    int unsigned bytes_sent;
    int unsigned dropped_sent;
    int unsigned burst_left;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            chain[i] = start_chain[i];
        fill = 0;
        bit_len = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + round_const[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [BYTE_W-1:0] value);
        block_bytes[fill] = value;
        fill++;
        bit_len += BYTE_BITS;
        if (fill == 64)
        begin
            compress_block();
            fill = 0;
        end
    endfunction

    // Pad, run the closing compression(s) and queue the eight words.
    function automatic void finish_message(input logic gold_valid,
                                           input logic [255:0] gold);
        int unsigned   pos;
        digest_entry_t entry;
        pos = fill;
        block_bytes[pos] = PAD_MARK;
        pos++;
        // no room for the length: close this block first
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = '0;
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_bytes[pos] = '0;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            entry.word = gold_valid ? gold[255 - 32*i -: 32] : chain[i];
            entry.idx  = i[IDX_W-1:0];
            entry.last = (entry.idx == IDX_LAST);
            pending_words = {pending_words, entry};
        end
        restart_hash();
    endfunction

    function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                            input logic [BYTE_W-1:0] value,
                                            input logic gold_valid,
                                            input logic [255:0] gold);
        if (kind == KIND_UNUSED)
        begin
            dropped_sent++;
            return;
        end
        if (kind == KIND_DATA || kind == KIND_LAST)
        begin
            absorb_byte(value);
            bytes_sent++;
        end
        if (kind != KIND_DATA)
        begin
            finish_message(gold_valid, gold);
            messages_sent++;
        end
    endfunction

    function automatic void add_row(input logic [KIND_W-1:0] kind,
                                    input logic [BYTE_W-1:0] value,
                                    input logic gold_valid,
                                    input logic [255:0] gold);
        stim_row_t row;
        row.kind       = kind;
        row.data_byte  = value;
        row.gold_valid = gold_valid;
        row.gold       = gold;
        stim_table = {stim_table, row};
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Drive one request at the falling edge and hold it until accepted.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [BYTE_W-1:0] value,
                                input logic gold_valid,
                                input logic [255:0] gold);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        msg_ch.valid     <= 1'b1;
        msg_ch.kind      <= kind;
        msg_ch.data_byte <= value;
        forever
        begin
            @(posedge clk);
            if (msg_ch.ready)
                break;
        end
        predict_request(kind, value, gold_valid, gold);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        msg_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d digest words still pending",
                 cycles, pending_words.size());
        $display("Mismatches found");
        $finish;
    end

    // Receiver: stall pattern switches between modes over random spans.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        dig_ch.ready = 1'b0;
        @(posedge rst_n);
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       dig_ch.ready <= 1'b1;
                    1:       dig_ch.ready <= 1'($urandom_range(0, 1));
                    2:       dig_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: dig_ch.ready <= (tick % 16 == 15);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_digest
        digest_entry_t want;
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("[%0t] unexpected digest word %h idx %0d last %0b", $realtime,
                             dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (dig_ch.digest_word !== want.word || dig_ch.word_index !== want.idx ||
                    dig_ch.last_word !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("[%0t] digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                 $realtime, want.word, want.idx, want.last,
                                 dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
                end
            end
        end
    end

    initial
    begin
        int unsigned random_items;
        int unsigned len;
        int unsigned r;
        logic        ends_with_last;
        logic [KIND_W-1:0] kind;

        rst_n            = 1'b0;
        msg_ch.valid     = 1'b0;
        msg_ch.kind      = KIND_DATA;
        msg_ch.data_byte = '0;
        mismatch_count   = 0;
        words_checked    = 0;
        messages_sent    = 0;
        bytes_sent       = 0;
        dropped_sent     = 0;
        burst_left       = 0;
        random_items     = 0;
        restart_hash();

        // empty message, then "abc", unused kind, byte extremes
        add_row(KIND_END,    8'h5a, 1'b1, EMPTY_DIGEST);
        add_row(KIND_DATA,   8'h61, 1'b0, '0);
        add_row(KIND_DATA,   8'h62, 1'b0, '0);
        add_row(KIND_LAST,   8'h63, 1'b1, ABC_DIGEST);
        add_row(KIND_UNUSED, 8'hff, 1'b0, '0);
        add_row(KIND_LAST,   8'h00, 1'b0, '0);
        add_row(KIND_DATA,   8'hff, 1'b0, '0);
        add_row(KIND_DATA,   8'h00, 1'b0, '0);
        add_row(KIND_UNUSED, 8'h00, 1'b0, '0);
        add_row(KIND_END,    8'hff, 1'b0, '0);
        add_row(KIND_LAST,   8'hff, 1'b0, '0);
        add_row(KIND_END,    8'h00, 1'b1, EMPTY_DIGEST);
        add_row(KIND_DATA,   8'h80, 1'b0, '0);
        add_row(KIND_DATA,   8'h7f, 1'b0, '0);
        add_row(KIND_LAST,   8'h01, 1'b0, '0);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
            send_request(stim_table[i].kind, stim_table[i].data_byte,
                         stim_table[i].gold_valid, stim_table[i].gold);
        hold_until_drained();

        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
            // mostly short messages; some sit on the padding and block edges
            r = $urandom_range(0, 99);
            if (r < 65)
                len = $urandom_range(0, 8);
            else if (r < 85)
                len = $urandom_range(9, 40);
            else if (r < 95)
                case ($urandom_range(0, 5))
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 57;
                    3:       len = 63;
                    4:       len = 64;
                    default: len = 65;
                endcase
            else
                len = $urandom_range(100, 130);
            ends_with_last = (len > 0) && $urandom_range(0, 1);
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    send_request(KIND_UNUSED, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                    random_items++;
                end
                kind = (ends_with_last && j == len - 1) ? KIND_LAST : KIND_DATA;
                send_request(kind, pick_byte(), 1'b0, '0);
            end
            if (!ends_with_last)
                send_request(KIND_END, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            random_items += len + (ends_with_last ? 0 : 1);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages (%0d bytes, %0d dropped requests), %0d words checked",
                 messages_sent, bytes_sent, dropped_sent, words_checked);
        $display("Mismatch count: %0d, words left pending: %0d",
                 mismatch_count, pending_words.size());
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
hdl/sha_pkg.sv
hdl/sha_in_if.sv
hdl/sha_out_if.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_message_hash.sv
tb/tb_sha256_message_hash.sv
